// ===== rtl/core/rahfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rahfp_pkg: shared types and constants of the radio hex frame parser
// Character codes, frame layout offsets, digit decoders and the result type.
// ----------------------------------------------------------------------------
package rahfp_pkg;

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_ZERO = 8'h30;

	localparam logic [3:0] HI_DIGIT = 4'h3;
	localparam logic [3:0] HI_ALPHA = 4'h4;
	localparam logic [4:0] ALPHA_OFS = 5'd9;

	// Header offsets: the first '0' of the sync is offset 0
	localparam logic [3:0] OFS_ENTRY     = 4'd2;
	localparam logic [3:0] ID_FIRST      = 4'd3;
	localparam logic [3:0] ID_LAST       = 4'd6;
	localparam logic [3:0] PAYLOAD_START = 4'd11;

	localparam int GROUP_MAX = 4;

	typedef struct packed {
		logic [15:0] sender_id;
		logic [7:0]  payload_byte;
		logic [4:0]  payload_index;
		logic        last;
	} rahfp_result_t;

	// ID digit: 0x30..0x3F ('0'..'9' and more) give the low nibble, anything else low nibble plus 9
	function automatic logic [4:0] id_digit(input logic [7:0] c);
		if (c[7:4] == HI_DIGIT) begin
			return {1'b0, c[3:0]};
		end
		return {1'b0, c[3:0]} + ALPHA_OFS;
	endfunction

	// Payload digit: 0x40..0x4F ('@'..'O') give low nibble plus 9, anything else the low nibble
	function automatic logic [4:0] payload_digit(input logic [7:0] c);
		if (c[7:4] == HI_ALPHA) begin
			return {1'b0, c[3:0]} + ALPHA_OFS;
		end
		return {1'b0, c[3:0]};
	endfunction

endpackage

// ===== rtl/core/rahfp_parser.sv =====
// ----------------------------------------------------------------------------
// rahfp_parser: sync search, header decode and payload byte assembly
// Advances one character per step and registers the decoded result.
// ----------------------------------------------------------------------------
module rahfp_parser #(
	parameter int MAX_PAYLOAD_BYTES = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [7:0]               char_in,
	input  logic [2:0]               groups,
	input  logic                     res_stall,
	output logic                     res_valid,
	output rahfp_pkg::rahfp_result_t res
);
	import rahfp_pkg::*;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_CR,
		ST_LF,
		ST_ZERO,
		ST_HEADER,
		ST_PAYLOAD
	} state_t;

	localparam logic [6:0] MAX_LEN = 7'(MAX_PAYLOAD_BYTES);

	state_t        state_q;
	logic [3:0]    hdr_ofs_q;
	logic [1:0]    phase_q;
	logic [4:0]    idx_q;
	logic [15:0]   id_q;
	logic [3:0]    upper_q;

	logic [4:0]    id_dig;
	logic [4:0]    pay_dig;
	logic [1:0]    id_pos;
	logic [15:0]   id_shifted;
	logic [2:0]    g_eff;
	logic [6:0]    pay_len;
	logic [6:0]    idx_next;
	logic          fin;
	logic [7:0]    byte_val;
	state_t        miss_state;

	always_comb begin
		id_dig     = id_digit(char_in);
		pay_dig    = payload_digit(char_in);
		id_pos     = 2'(ID_LAST - hdr_ofs_q);
		id_shifted = {11'b0, id_dig} << {id_pos, 2'b00};
		byte_val   = {upper_q, 4'b0000} | {3'b000, pay_dig};

		// clamp group count to one..four, then cap the length
		if (groups == 3'd0) begin
			g_eff = 3'd1;
		end else if (groups > 3'(GROUP_MAX)) begin
			g_eff = 3'(GROUP_MAX);
		end else begin
			g_eff = groups;
		end
		pay_len  = (({1'b0, g_eff, 3'b000}) > MAX_LEN) ? MAX_LEN : {1'b0, g_eff, 3'b000};
		idx_next = {2'b00, idx_q} + 7'd1;
		fin      = (idx_next >= pay_len);

		// a broken sync restarts, with a CR counting as the first character
		miss_state = (char_in == CH_CR) ? ST_CR : ST_HUNT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_HUNT;
			hdr_ofs_q <= 4'd0;
			phase_q   <= 2'd0;
			idx_q     <= 5'd0;
			id_q      <= 16'd0;
			upper_q   <= 4'd0;
			res_valid <= 1'b0;
			res       <= '0;
		end else if (step) begin
			res_valid <= 1'b0;
			case (state_q)
				ST_HUNT: begin
					state_q <= miss_state;
				end
				ST_CR: begin
					state_q <= (char_in == CH_LF) ? ST_LF : miss_state;
				end
				ST_LF: begin
					state_q <= (char_in == CH_ZERO) ? ST_ZERO : miss_state;
				end
				ST_ZERO: begin
					if (char_in == CH_ZERO) begin
						state_q   <= ST_HEADER;
						hdr_ofs_q <= OFS_ENTRY;
						phase_q   <= 2'd0;
						idx_q     <= 5'd0;
						id_q      <= 16'd0;
						upper_q   <= 4'd0;
					end else begin
						state_q <= miss_state;
					end
				end
				ST_HEADER: begin
					if (hdr_ofs_q >= ID_FIRST && hdr_ofs_q <= ID_LAST) begin
						id_q <= id_q | id_shifted;
					end
					if (hdr_ofs_q == PAYLOAD_START - 4'd1) begin
						state_q <= ST_PAYLOAD;
					end
					hdr_ofs_q <= hdr_ofs_q + 4'd1;
				end
				ST_PAYLOAD: begin
					case (phase_q)
						2'd0: begin
							upper_q <= pay_dig[3:0];
							phase_q <= 2'd1;
						end
						2'd1: begin
							res_valid         <= 1'b1;
							res.sender_id     <= id_q;
							res.payload_byte  <= byte_val;
							res.payload_index <= idx_q;
							res.last          <= fin;
							phase_q           <= 2'd2;
							if (fin) begin
								state_q <= ST_HUNT;
							end
						end
						default: begin
							phase_q <= 2'd0;
							idx_q   <= idx_q + 5'd1;
						end
					endcase
				end
				default: begin
					state_q <= ST_HUNT;
				end
			endcase
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/radio_ascii_hex_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// radio_ascii_hex_frame_parser_core: radio module ASCII hex frame parser
// Finds CR LF '0' '0' frames in a UART byte stream and emits decoded bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Feed received characters on the input channel (in_valid, in_stall,
//   rx_byte). A transfer happens when valid is high and stall is low.
//   After the sync sequence the four hex digits of the sender ID are
//   decoded; each payload byte (high digit, low digit, separator) yields
//   one transfer on the output channel carrying sender_id, payload_byte,
//   payload_index and last. The payload is 8 * payload_groups bytes long
//   (groups clamped to 1..4, length capped at MAX_PAYLOAD_BYTES).
// Throughput: one character per cycle, sustained while out_stall is low.
// Path: a low digit passes the input register, then the result register.
// Stall: while a result waits under out_stall, the character in the input
//   register is held and in_stall is raised; the result register and the
//   input register together keep both sides moving otherwise.
// Reset: arst_n clears the sync search, the frame state and both valid
//   flags; payload_groups returns to 1.
// Configuration: write payload_groups through cfg_we/cfg_wdata while idle.
// ----------------------------------------------------------------------------
module radio_ascii_hex_frame_parser_core #(
	parameter int MAX_PAYLOAD_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] sender_id,
	output logic [7:0]  payload_byte,
	output logic [4:0]  payload_index,
	output logic        last
);
	import rahfp_pkg::*;

	logic [2:0]    payload_groups_q;
	logic          valid_s1;
	logic [7:0]    rx_byte_s1;
	logic          advance;
	rahfp_result_t res;

	// Advance the held character when the result register is free or drains
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Hold the group count; it is read on every character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_groups_q <= 3'd1;
		end else if (cfg_we) begin
			payload_groups_q <= cfg_wdata;
		end
	end

	// Input register: take a new character whenever the stage is not held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	rahfp_parser #(
		.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.char_in   (rx_byte_s1),
		.groups    (payload_groups_q),
		.res_stall (out_stall),
		.res_valid (out_valid),
		.res       (res)
	);

	assign sender_id     = res.sender_id;
	assign payload_byte  = res.payload_byte;
	assign payload_index = res.payload_index;
	assign last          = res.last;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for radio_ascii_hex_frame_parser_core
// Streams characters (broken syncs, noise and randomized radio frames)
// through the parser. The payload_tracker class decodes the same stream
// and checks every emitted byte in order. Random valid gaps and output
// stalls run on both channels outside the calm last phase. The group count
// is changed between phases, including once in the middle of an open frame.
// ----------------------------------------------------------------------------
module testbench;
	import rahfp_pkg::*;

	localparam int MAX_BYTES    = 32;
	localparam int PHASE_CHARS  = 30;
	localparam int SETTLE_TICKS = 6;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int NUM_PHASES   = 6;

	localparam logic [2:0] GROUP_PLAN [NUM_PHASES] = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd1};

	// Software twin of the parser: tracks sync, header and payload position
	// and queues the byte each low digit is expected to produce.
	class payload_tracker;
		rahfp_result_t expected_bytes[$];
		logic [2:0]    groups;
		logic [1:0]    sync_hits;
		bit            framing;
		logic [6:0]    next_ofs;
		logic [15:0]   id_word;
		logic [3:0]    high_nib;
		int            failures;

		function new();
			groups    = 3'd1;
			sync_hits = 2'd0;
			framing   = 1'b0;
			next_ofs  = 7'd0;
			id_word   = 16'h0000;
			high_nib  = 4'h0;
			failures  = 0;
		endfunction

		function int unsigned frame_len();
			int unsigned g;
			int unsigned n;
			g = 32'(groups);
			if (g < 1) begin
				g = 1;
			end
			if (g > GROUP_MAX) begin
				g = GROUP_MAX;
			end
			n = g * 8;
			if (n > MAX_BYTES) begin
				n = MAX_BYTES;
			end
			return n;
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		function void take_char(logic [7:0] c);
			int unsigned   ofs;
			int unsigned   rel;
			int unsigned   k;
			int unsigned   sh;
			logic [4:0]    dig;
			rahfp_result_t r;
			if (!framing) begin
				case (sync_hits)
					2'd0: begin
						sync_hits = (c == CH_CR) ? 2'd1 : 2'd0;
					end
					2'd1: begin
						sync_hits = (c == CH_LF) ? 2'd2 : ((c == CH_CR) ? 2'd1 : 2'd0);
					end
					2'd2: begin
						sync_hits = (c == CH_ZERO) ? 2'd3 : ((c == CH_CR) ? 2'd1 : 2'd0);
					end
					default: begin
						if (c == CH_ZERO) begin
							sync_hits = 2'd0;
							framing   = 1'b1;
							next_ofs  = 7'(OFS_ENTRY);
							id_word   = 16'h0000;
							high_nib  = 4'h0;
						end else begin
							sync_hits = (c == CH_CR) ? 2'd1 : 2'd0;
						end
					end
				endcase
				return;
			end
			ofs      = 32'(next_ofs);
			next_ofs = next_ofs + 7'd1;
			// Header: four ID digits, anything outside 0x30..0x3F takes the +9 path
			if (ofs >= ID_FIRST && ofs <= ID_LAST) begin
				dig = (c[7:4] == HI_DIGIT) ? {1'b0, c[3:0]} : {1'b0, c[3:0]} + ALPHA_OFS;
				sh  = (ID_LAST - ofs) * 4;
				// a digit above 15 spills into the next digit; drop bits past 16
				id_word = id_word | (16'(dig) << sh);
				return;
			end
			if (ofs < PAYLOAD_START) begin
				return;
			end
			rel = ofs - PAYLOAD_START;
			k   = rel / 3;
			dig = (c[7:4] == HI_ALPHA) ? {1'b0, c[3:0]} + ALPHA_OFS : {1'b0, c[3:0]};
			if (rel % 3 == 0) begin
				high_nib = dig[3:0];
				return;
			end
			if (rel % 3 == 2) begin
				return;
			end
			r.sender_id     = id_word;
			r.payload_byte  = {high_nib, 4'h0} | {3'b000, dig};
			r.payload_index = k[4:0];
			r.last          = (k + 1 >= frame_len());
			expected_bytes.push_back(r);
			if (r.last) begin
				framing   = 1'b0;
				next_ofs  = 7'd0;
				sync_hits = 2'd0;
			end
		endfunction

		function void match_byte(logic [15:0] id, logic [7:0] b, logic [4:0] idx,
				logic fin);
			rahfp_result_t e;
			if (expected_bytes.size() == 0) begin
				failures++;
				if (failures <= 10) begin
					$display("unexpected byte: id=%h byte=%h idx=%0d last=%b",
						id, b, idx, fin);
				end
				return;
			end
			e = expected_bytes.pop_front();
			if (e.sender_id !== id || e.payload_byte !== b || e.payload_index !== idx
					|| e.last !== fin) begin
				failures++;
				if (failures <= 10) begin
					$display("byte mismatch: exp id=%h byte=%h idx=%0d last=%b,",
						e.sender_id, e.payload_byte, e.payload_index, e.last,
						" got id=%h byte=%h idx=%0d last=%b", id, b, idx, fin);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_wdata = 3'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] sender_id;
	logic [7:0]  payload_byte;
	logic [4:0]  payload_index;
	logic        last;

	payload_tracker sb;
	logic [7:0]     line_chars[$];
	bit             calm = 1'b0;
	int             stall_left = 0;
	int             cycles = 0;

	radio_ascii_hex_frame_parser_core #(
		.MAX_PAYLOAD_BYTES(MAX_BYTES)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sender_id    (sender_id),
		.payload_byte (payload_byte),
		.payload_index(payload_index),
		.last         (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: end the run if the stream or the drain hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Output side: check each transfer, then decide the stall for the next edge.
	// Stall comes in bursts of random length; hold it low in the calm phase.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.match_byte(sender_id, payload_byte, payload_index, last);
		end
		if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!calm && arst_n && $urandom_range(0, 7) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 5);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Mostly real characters: decimal digits and both letter cases, with the
	// odd arbitrary byte to push the nibble rules past plain hex.
	function automatic logic [7:0] pick_digit_char();
		case ($urandom_range(0, 7))
			0, 1, 2: return 8'h30 + 8'($urandom_range(0, 9));
			3, 4:    return 8'h41 + 8'($urandom_range(0, 5));
			5:       return 8'h61 + 8'($urandom_range(0, 5));
			6:       return 8'h40 + 8'($urandom_range(0, 15));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Separators: ':' or space half the time, but CR, LF, '0' and random bytes too, which must not resync
	function automatic logic [7:0] pick_sep_char();
		case ($urandom_range(0, 7))
			0:       return CH_CR;
			1:       return CH_LF;
			2:       return CH_ZERO;
			3:       return 8'($urandom_range(0, 255));
			4, 5:    return 8'h20;
			default: return 8'h3A;
		endcase
	endfunction

	// Queue one frame. On a broken sync the body turns into plain noise.
	// cut >= 0: stop right after the high digit of payload byte cut.
	task automatic build_frame(input int cut);
		int unsigned len;
		len = sb.frame_len();
		repeat ($urandom_range(0, 3)) begin
			line_chars.push_back(($urandom_range(0, 3) == 0) ? CH_CR : 8'($urandom_range(0, 255)));
		end
		line_chars.push_back(CH_CR);
		line_chars.push_back(CH_LF);
		line_chars.push_back(CH_ZERO);
		line_chars.push_back(($urandom_range(0, 7) == 0) ? pick_digit_char() : CH_ZERO);
		// offsets 2..10: spare header char, ID digits, then the filler field
		for (int i = 2; i <= 10; i++) begin
			line_chars.push_back((i == 10) ? pick_sep_char() : pick_digit_char());
		end
		for (int i = 0; i < int'(len); i++) begin
			line_chars.push_back(pick_digit_char());
			if (i == cut) begin
				return;
			end
			line_chars.push_back(pick_digit_char());
			if (i < int'(len) - 1) begin
				line_chars.push_back(pick_sep_char());
			end
		end
		if ($urandom_range(0, 1) == 0) begin
			line_chars.push_back(CH_CR);
			line_chars.push_back(CH_LF);
		end
	endtask

	// Hold valid and the character until the transfer, then note it
	task automatic send_char(input logic [7:0] c);
		in_valid <= 1'b1;
		rx_byte  <= c;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.take_char(c);
	endtask

	// Drain the queued line, dropping valid for random bursts in between
	task automatic send_line();
		int gap;
		while (line_chars.size() != 0) begin
			if (!calm && $urandom_range(0, 7) == 0) begin
				gap      = $urandom_range(1, 6);
				in_valid <= 1'b0;
				rx_byte  <= 8'($urandom_range(0, 255));
				repeat (gap) @(posedge clk);
			end
			send_char(line_chars.pop_front());
		end
	endtask

	// Wait until the parser is idle: nothing expected and the pipe flushed
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_groups(input logic [2:0] g);
		cfg_we    <= 1'b1;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.groups = g;
	endtask

	initial begin
		// phase 0 runs at the reset value; out-of-range counts in between.
		// Phase 1 leaves a long frame open at byte 12 and phase 2 shrinks the
		// length to 8, so the next low digit must close the frame.
		int         phase_chars;
		int         cut;

		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme bytes and broken syncs, including a CR restarting the search at each stage
		line_chars = '{8'h00, 8'hFF, CH_CR, CH_CR, CH_LF, CH_CR, CH_LF, CH_ZERO, CH_CR,
			CH_LF, CH_ZERO, 8'h31, CH_LF, CH_ZERO, CH_ZERO, CH_CR, CH_LF, CH_ZERO, CH_CR};
		send_line();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				settle();
				write_groups(GROUP_PLAN[ph]);
			end
			if (ph == NUM_PHASES - 1) begin
				calm = 1'b1;
			end
			phase_chars = 0;
			while (phase_chars < PHASE_CHARS) begin
				build_frame(-1);
				phase_chars += line_chars.size();
				send_line();
			end
			// End some phases inside an open frame
			if (ph == 1) begin
				cut = 12;
			end else if (ph < NUM_PHASES - 1 && $urandom_range(0, 1) == 0) begin
				cut = $urandom_range(0, sb.frame_len() - 1);
			end else begin
				cut = -1;
			end
			if (cut >= 0) begin
				build_frame(cut);
				send_line();
			end
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
